// ===== hw/rtl/psu_pkg.sv =====
package psu_pkg;

    localparam int MAX_DEPTH = 16;
    localparam int BUF_W     = MAX_DEPTH + 7;
    localparam int HELD_W    = $clog2(BUF_W + 1);
    localparam int DEPTH_W   = 5;
    localparam int SAMPLE_W  = 17;
    localparam int ROW_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int CNT_W     = 3;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_BIT_DEPTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIGNED    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH = 2'd3;

    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 5'd8;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;      // effective depth, 1..MAX_DEPTH
        logic               invert;
        logic               signed_en;
    } cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [HELD_W-1:0]          held_left;
        logic [BUF_W-1:0]           buf_left;
    } extract_t;

endpackage

// ===== hw/rtl/packed_sample_unpacker_unit.sv =====
// Channel  | Signals                          | Dir | Width
// ---------+----------------------------------+-----+------------------------
// in       | in_valid, in_stall, data_byte    | in  | 8-bit byte, MSB first
// out      | out_valid, out_stall, sample,    | out | 17-bit signed sample,
//          | row_end, byte_done               |     | 1-bit flags
// cfg      | cfg_write_en, cfg_index, cfg_wdata | in | 2-bit index, 16-bit data
//
// One sample per cycle leaves through the output register while out_stall
// is low; a byte yields up to 8 samples (at depth 1), and a byte that yields
// nothing is absorbed without stalling the input. The next byte is taken in the cycle the
// last sample of the current byte is loaded into the output register.
// rst_n clears the bit buffer, the row count and the configuration (depth 8,
// row width 1). A stall on the output holds extraction and, through it, the
// input; the output register lets a finished sample wait while work goes on.
module packed_sample_unpacker_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [7:0]                           data_byte,

    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [psu_pkg::SAMPLE_W-1:0]  sample,
    output logic                                 row_end,
    output logic                                 byte_done,

    input  logic                                 cfg_write_en,
    input  logic [psu_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [psu_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    // configuration registers
    logic [psu_pkg::DEPTH_W-1:0] bit_depth_reg;
    logic                        invert_reg;
    logic                        signed_reg;
    logic [psu_pkg::ROW_W-1:0]   row_width_reg;

    // bit buffer state: low held_reg bits of buf_reg are valid
    logic [psu_pkg::BUF_W-1:0]   buf_reg, buf_next;
    logic [psu_pkg::HELD_W-1:0]  held_reg, held_next;
    logic [psu_pkg::ROW_W-1:0]   row_cnt_reg, row_cnt_next;
    // active_reg: current byte still has samples to give
    logic                        active_reg, active_next;
    logic [psu_pkg::CNT_W-1:0]   cnt_reg, cnt_next;

    // output register
    logic                                out_valid_reg, out_valid_next;
    logic signed [psu_pkg::SAMPLE_W-1:0] sample_reg;
    logic                                row_end_reg;
    logic                                byte_done_reg;

    psu_pkg::cfg_t     cfg;
    psu_pkg::extract_t ex;

    logic                        slot_free;
    logic                        emit;
    logic                        last;
    logic                        at_row_end;
    logic [psu_pkg::ROW_W-1:0]   row_inc;
    logic [psu_pkg::HELD_W-1:0]  held_after;
    logic [psu_pkg::BUF_W-1:0]   buf_after;
    logic                        take;
    logic [psu_pkg::BUF_W-1:0]   merged_buf;
    logic [psu_pkg::HELD_W-1:0]  merged_held;

    // depth zero acts as 1, anything past the maximum saturates
    always_comb
    begin
        priority if (bit_depth_reg == '0)
        begin
            cfg.depth = psu_pkg::DEPTH_W'(1);
        end
        else if (bit_depth_reg > psu_pkg::DEPTH_W'(psu_pkg::MAX_DEPTH))
        begin
            cfg.depth = psu_pkg::DEPTH_W'(psu_pkg::MAX_DEPTH);
        end
        else
        begin
            cfg.depth = bit_depth_reg;
        end
        cfg.invert    = invert_reg;
        cfg.signed_en = signed_reg;
    end

    psu_extract u_extract (
        .bits_in (buf_reg),
        .held    (held_reg),
        .cfg     (cfg),
        .res     (ex)
    );

    always_comb
    begin
        slot_free  = !out_valid_reg || !out_stall;
        emit       = active_reg && slot_free;
        row_inc    = row_cnt_reg + psu_pkg::ROW_W'(1);
        at_row_end = (row_inc == row_width_reg);

        // a finished row drops whatever bits are still held
        held_after = at_row_end ? '0 : ex.held_left;
        buf_after  = at_row_end ? '0 : ex.buf_left;

        last = at_row_end
            || (held_after < psu_pkg::HELD_W'(cfg.depth))
            || (cnt_reg == psu_pkg::CNT_W'(7));

        in_stall = active_reg && !(emit && last);
        take     = in_valid && !in_stall;

        // state the new byte is appended to
        held_next    = held_reg;
        buf_next     = buf_reg;
        row_cnt_next = row_cnt_reg;
        active_next  = active_reg;
        cnt_next     = cnt_reg;
        if (emit)
        begin
            held_next    = held_after;
            buf_next     = buf_after;
            row_cnt_next = at_row_end ? '0 : row_inc;
            cnt_next     = cnt_reg + psu_pkg::CNT_W'(1);
            if (last)
            begin
                active_next = 1'b0;
            end
        end

        merged_buf  = {buf_next[psu_pkg::BUF_W-9:0], data_byte};
        merged_held = held_next + psu_pkg::HELD_W'(8);
        if (take)
        begin
            buf_next    = merged_buf;
            held_next   = merged_held;
            cnt_next    = '0;
            active_next = (merged_held >= psu_pkg::HELD_W'(cfg.depth));
        end

        out_valid_next = emit || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_depth_reg <= psu_pkg::DEPTH_RESET;
            invert_reg    <= 1'b0;
            signed_reg    <= 1'b0;
            row_width_reg <= psu_pkg::ROW_W'(1);
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                psu_pkg::REG_BIT_DEPTH: bit_depth_reg <= cfg_wdata[psu_pkg::DEPTH_W-1:0];
                psu_pkg::REG_INVERT:    invert_reg    <= cfg_wdata[0];
                psu_pkg::REG_SIGNED:    signed_reg    <= cfg_wdata[0];
                psu_pkg::REG_ROW_WIDTH: row_width_reg <= cfg_wdata[psu_pkg::ROW_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg       <= '0;
            held_reg      <= '0;
            row_cnt_reg   <= '0;
            active_reg    <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            buf_reg       <= buf_next;
            held_reg      <= held_next;
            row_cnt_reg   <= row_cnt_next;
            active_reg    <= active_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, loaded only when a sample is produced
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            sample_reg    <= ex.sample;
            row_end_reg   <= at_row_end;
            byte_done_reg <= last;
        end
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;
    assign row_end   = row_end_reg;
    assign byte_done = byte_done_reg;

`ifndef ASSERT_OFF
    // while extracting, there are always enough bits for a full sample
    a_active_has_bits: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (held_reg >= psu_pkg::HELD_W'(cfg.depth)))
        else $error("extracting without a full sample held");

    // buffer never holds more than its width
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= psu_pkg::HELD_W'(psu_pkg::BUF_W))
        else $error("bit count past buffer width");

    // end of row always closes the byte's sample run
    a_row_end_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && row_end_reg) |-> byte_done_reg)
        else $error("row end without byte done");

    // a new byte while busy only lands together with the last sample
    a_take_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (take && active_reg) |-> (emit && last))
        else $error("byte taken mid-extraction");

    // no more than eight samples come out of one byte
    a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && (cnt_reg == psu_pkg::CNT_W'(7))) |-> last)
        else $error("more than eight samples from one byte");
`endif

endmodule

// ===== hw/rtl/psu_extract.sv =====
// Takes the top depth bits of the held bits, applies invert and sign
// extension, and returns the remaining bits.
module psu_extract (
    input  logic [psu_pkg::BUF_W-1:0]  bits_in,
    input  logic [psu_pkg::HELD_W-1:0] held,
    input  psu_pkg::cfg_t              cfg,
    output psu_pkg::extract_t          res
);

    logic [psu_pkg::HELD_W-1:0]    shamt;
    logic [psu_pkg::BUF_W-1:0]     shifted;
    logic [psu_pkg::MAX_DEPTH:0]   mask_wide;
    logic [psu_pkg::MAX_DEPTH-1:0] mask;
    logic [psu_pkg::MAX_DEPTH-1:0] raw;
    logic [psu_pkg::MAX_DEPTH-1:0] val;
    logic [psu_pkg::DEPTH_W-1:0]   dm1;
    logic                          sign_depth;
    logic                          neg;
    logic [psu_pkg::SAMPLE_W-1:0]  ext;
    logic [psu_pkg::HELD_W-1:0]    left;
    logic [psu_pkg::BUF_W-1:0]     keep;

    always_comb
    begin
        shamt     = held - psu_pkg::HELD_W'(cfg.depth);
        shifted   = bits_in >> shamt;
        mask_wide = ((psu_pkg::MAX_DEPTH+1)'(1) << cfg.depth) - (psu_pkg::MAX_DEPTH+1)'(1);
        mask      = mask_wide[psu_pkg::MAX_DEPTH-1:0];
        raw       = shifted[psu_pkg::MAX_DEPTH-1:0] & mask;
        val       = cfg.invert ? (raw ^ mask) : raw;

        // sign extension is only defined for 4, 10 and 12 bit samples
        sign_depth = (cfg.depth == psu_pkg::DEPTH_W'(4))
                  || (cfg.depth == psu_pkg::DEPTH_W'(10))
                  || (cfg.depth == psu_pkg::DEPTH_W'(12));
        dm1 = cfg.depth - psu_pkg::DEPTH_W'(1);
        neg = cfg.signed_en && sign_depth && val[dm1[3:0]];
        ext = {1'b0, val};
        if (neg)
        begin
            ext = ext - (psu_pkg::SAMPLE_W'(1) << cfg.depth);
        end

        left = shamt;
        keep = ~({psu_pkg::BUF_W{1'b1}} << left);

        res.sample    = ext;
        res.held_left = left;
        res.buf_left  = bits_in & keep;
    end

endmodule

// ===== tb/packed_sample_unpacker_unit_tb.sv =====
module packed_sample_unpacker_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Quiet cycles allowed before the run is declared hung. The longest
    // legitimate quiet stretch is the receiver hold-off or a settle.
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int TAIL_CYCLES     = 20;
    localparam int LONG_HOLD       = 60;
    localparam int N_PHASES        = 9;
    localparam int ITEMS_PER_PHASE = 28;
    localparam int MAX_PER_BYTE    = 8;
    localparam int N_DIR           = 42;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_BYTE
    } row_kind_t;

    // One directed step: a register write or a byte. Byte rows may carry a
    // hand-typed expectation (exactly one sample, byte_done set).
    typedef struct packed {
        row_kind_t                       kind;
        logic [psu_pkg::CFG_IDX_W-1:0]   idx;
        logic [psu_pkg::CFG_DATA_W-1:0]  value;
        logic                            typed;
        logic [psu_pkg::SAMPLE_W-1:0]    t_sample;
        logic                            t_end;
    } dir_row_t;

    typedef struct packed {
        logic [psu_pkg::SAMPLE_W-1:0] sample;
        logic                         row_end;
        logic                         byte_done;
    } sample_exp_t;

    typedef struct packed {
        logic                         typed;
        logic [psu_pkg::SAMPLE_W-1:0] t_sample;
        logic                         t_end;
    } offered_t;

    logic                                clk = 1'b0;
    logic                                rst_n;
    logic                                in_valid;
    logic                                in_stall;
    logic [7:0]                          data_byte;
    logic                                out_valid;
    logic                                out_stall;
    logic signed [psu_pkg::SAMPLE_W-1:0] sample;
    logic                                row_end;
    logic                                byte_done;
    logic                                cfg_write_en;
    logic [psu_pkg::CFG_IDX_W-1:0]       cfg_index;
    logic [psu_pkg::CFG_DATA_W-1:0]      cfg_wdata;

    always #2 clk = ~clk;

    packed_sample_unpacker_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sample       (sample),
        .row_end      (row_end),
        .byte_done    (byte_done),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Predictor state: mirrored configuration plus the unpacker's own
    // bit buffer, held-bit count and per-row sample count.
    // ------------------------------------------------------------------
    logic [psu_pkg::DEPTH_W-1:0] cur_depth     = psu_pkg::DEPTH_RESET;
    logic                        cur_invert    = 1'b0;
    logic                        cur_signed    = 1'b0;
    logic [psu_pkg::ROW_W-1:0]   cur_row_width = 16'd1;

    logic [31:0]                 held_bits  = '0;
    int                          held_n     = 0;
    logic [psu_pkg::ROW_W-1:0]   row_count  = '0;

    sample_exp_t        step_res [MAX_PER_BYTE];
    sample_exp_t        pending_samples [$];
    offered_t           offered_bytes [$];

    int                 mismatches   = 0;
    int                 quiet_cycles = 0;

    // Receiver controls, set by the stimulus thread per phase.
    bit                 rx_eager = 1'b0;
    int                 hold_req = 0;

    // Directed table. Rows with typed = 1 have their sample written out by
    // hand; everything else goes through the predictor.
    dir_row_t dir_rows [N_DIR] = '{
        // reset defaults: depth 8, one sample per row
        '{ROW_BYTE,  psu_pkg::REG_BIT_DEPTH, 16'h00A5, 1'b1, 17'd165, 1'b1},
        '{ROW_BYTE,  psu_pkg::REG_BIT_DEPTH, 16'h0000, 1'b1, 17'd0,   1'b1},
        '{ROW_BYTE,  psu_pkg::REG_BIT_DEPTH, 16'h00FF, 1'b1, 17'd255, 1'b1},
        // invert at depth 8 flips the extremes
        '{ROW_WRITE, psu_pkg::REG_INVERT,    16'h0001, 1'b0, 17'd0,   1'b0},
        '{ROW_BYTE,  psu_pkg::REG_BIT_DEPTH, 16'h0000, 1'b1, 17'd255, 1'b1},
        '{ROW_BYTE,  psu_pkg::REG_BIT_DEPTH, 16'h00FF, 1'b1, 17'd0,   1'b1},
        // signed nibbles, row of four
        '{ROW_WRITE, psu_pkg::REG_BIT_DEPTH, 16'h0004, 1'b0, 17'd0,   1'b0},
        '{ROW_WRITE, psu_pkg::REG_SIGNED,    16'h0001, 1'b0, 17'd0,   1'b0},
        '{ROW_WRITE, psu_pkg::REG_ROW_WIDTH, 16'h0004, 1'b0, 17'd0,   1'b0},
        '{ROW_WRITE, psu_pkg::REG_INVERT,    16'h0000, 1'b0, 17'd0,   1'b0},
        '{ROW_BYTE,  psu_pkg::REG_BIT_DEPTH, 16'h007F, 1'b0, 17'd0,   1'b0},
        '{ROW_BYTE,  psu_pkg::REG_BIT_DEPTH, 16'h0080, 1'b0, 17'd0,   1'b0},
        // invert first, then sign-extend
        '{ROW_WRITE, psu_pkg::REG_INVERT,    16'h0001, 1'b0, 17'd0,   1'b0},
        '{ROW_BYTE,  psu_pkg::REG_BIT_DEPTH, 16'h000F, 1'b0, 17'd0,   1'b0},
        '{ROW_BYTE,  psu_pkg::REG_BIT_DEPTH, 16'h0087, 1'b0, 17'd0,   1'b0},
        // 12-bit signed, inverted, rows of three (row end drops tail bits)
        '{ROW_WRITE, psu_pkg::REG_BIT_DEPTH, 16'h000C, 1'b0, 17'd0,   1'b0},
        '{ROW_WRITE, psu_pkg::REG_ROW_WIDTH, 16'h0003, 1'b0, 17'd0,   1'b0},
        '{ROW_BYTE,  psu_pkg::REG_BIT_DEPTH, 16'h0080, 1'b0, 17'd0,   1'b0},
        '{ROW_BYTE,  psu_pkg::REG_BIT_DEPTH, 16'h0000, 1'b0, 17'd0,   1'b0},
        '{ROW_BYTE,  psu_pkg::REG_BIT_DEPTH, 16'h00FF, 1'b0, 17'd0,   1'b0},
        '{ROW_BYTE,  psu_pkg::REG_BIT_DEPTH, 16'h007F, 1'b0, 17'd0,   1'b0},
        // 10-bit signed, plain
        '{ROW_WRITE, psu_pkg::REG_BIT_DEPTH, 16'h000A, 1'b0, 17'd0,   1'b0},
        '{ROW_WRITE, psu_pkg::REG_INVERT,    16'h0000, 1'b0, 17'd0,   1'b0},
        '{ROW_BYTE,  psu_pkg::REG_BIT_DEPTH, 16'h0080, 1'b0, 17'd0,   1'b0},
        '{ROW_BYTE,  psu_pkg::REG_BIT_DEPTH, 16'h0040, 1'b0, 17'd0,   1'b0},
        '{ROW_BYTE,  psu_pkg::REG_BIT_DEPTH, 16'h00FF, 1'b0, 17'd0,   1'b0},
        '{ROW_BYTE,  psu_pkg::REG_BIT_DEPTH, 16'h0001, 1'b0, 17'd0,   1'b0},
        // depth 16 with signed still on (ignored), widest row
        '{ROW_WRITE, psu_pkg::REG_BIT_DEPTH, 16'h0010, 1'b0, 17'd0,   1'b0},
        '{ROW_WRITE, psu_pkg::REG_ROW_WIDTH, 16'hFFFF, 1'b0, 17'd0,   1'b0},
        '{ROW_BYTE,  psu_pkg::REG_BIT_DEPTH, 16'h00C3, 1'b0, 17'd0,   1'b0},
        // depth drops to 1 with bits held: more than eight ready, capped
        '{ROW_WRITE, psu_pkg::REG_BIT_DEPTH, 16'h0001, 1'b0, 17'd0,   1'b0},
        '{ROW_BYTE,  psu_pkg::REG_BIT_DEPTH, 16'h005A, 1'b0, 17'd0,   1'b0},
        '{ROW_BYTE,  psu_pkg::REG_BIT_DEPTH, 16'h0000, 1'b0, 17'd0,   1'b0},
        // depth zero acts as one
        '{ROW_WRITE, psu_pkg::REG_BIT_DEPTH, 16'h0000, 1'b0, 17'd0,   1'b0},
        '{ROW_BYTE,  psu_pkg::REG_BIT_DEPTH, 16'h0096, 1'b0, 17'd0,   1'b0},
        // depth above the maximum saturates; row width zero wraps
        '{ROW_WRITE, psu_pkg::REG_BIT_DEPTH, 16'h001F, 1'b0, 17'd0,   1'b0},
        '{ROW_WRITE, psu_pkg::REG_ROW_WIDTH, 16'h0000, 1'b0, 17'd0,   1'b0},
        '{ROW_BYTE,  psu_pkg::REG_BIT_DEPTH, 16'h0012, 1'b0, 17'd0,   1'b0},
        '{ROW_BYTE,  psu_pkg::REG_BIT_DEPTH, 16'h0034, 1'b0, 17'd0,   1'b0},
        // signed mode at depth 8 is ignored
        '{ROW_WRITE, psu_pkg::REG_BIT_DEPTH, 16'h0008, 1'b0, 17'd0,   1'b0},
        '{ROW_BYTE,  psu_pkg::REG_BIT_DEPTH, 16'h0080, 1'b0, 17'd0,   1'b0},
        '{ROW_BYTE,  psu_pkg::REG_BIT_DEPTH, 16'h007F, 1'b0, 17'd0,   1'b0}
    };

    // Pushes one byte into the predictor's bit buffer and extracts what it
    // yields into step_res[0 .. n-1]. At most eight samples per byte; any
    // extra bits stay held for the next byte.
    task automatic unpack_byte(input logic [7:0] b, output int n);
        int          d;
        logic [31:0] mask;
        logic [31:0] v;
        logic        last_in_row;
        begin
            if (cur_depth == '0)
                d = 1;
            else if (int'(cur_depth) > psu_pkg::MAX_DEPTH)
                d = psu_pkg::MAX_DEPTH;
            else
                d = int'(cur_depth);
            mask = (32'd1 << d) - 32'd1;
            n = 0;
            held_bits = (held_bits << 8) | {24'd0, b};
            held_n += 8;
            while (held_n >= d && n < MAX_PER_BYTE)
            begin
                v = (held_bits >> (held_n - d)) & mask;
                held_n -= d;
                held_bits &= (32'd1 << held_n) - 32'd1;
                if (cur_invert)
                    v ^= mask;
                // sign extension only exists for 4, 10 and 12 bits
                if (cur_signed && (d == 4 || d == 10 || d == 12) && v[d-1])
                    v = v - (32'd1 << d);
                row_count = row_count + 16'd1;
                last_in_row = (row_count == cur_row_width);
                if (last_in_row)
                begin
                    // row done: realign to the next byte boundary
                    row_count = '0;
                    held_n = 0;
                    held_bits = '0;
                end
                step_res[n] = '{v[psu_pkg::SAMPLE_W-1:0], last_in_row, 1'b0};
                n++;
            end
            if (n > 0)
                step_res[n-1].byte_done = 1'b1;
        end
    endtask

    task automatic note_mismatch(input string what, input sample_exp_t want,
                                 input sample_exp_t got);
        begin
            mismatches++;
            if (mismatches <= 10)
                $display({"%s: expected sample %0d row_end %0b byte_done %0b,",
                          " got sample %0d row_end %0b byte_done %0b"},
                         what, $signed(want.sample), want.row_end, want.byte_done,
                         $signed(got.sample), got.row_end, got.byte_done);
        end
    endtask

    // ------------------------------------------------------------------
    // Scoreboard: mirrors config writes, predicts on every accepted byte,
    // and checks each accepted sample against the oldest expectation.
    // Everything here samples the pre-edge values, so it is race free.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : scoreboard
        offered_t    rec;
        sample_exp_t got;
        sample_exp_t want;
        int          n;
        bit          busy;
        if (rst_n)
        begin
            busy = 1'b0;
            if (cfg_write_en)
            begin
                busy = 1'b1;
                unique case (cfg_index)
                    psu_pkg::REG_BIT_DEPTH: cur_depth     = cfg_wdata[psu_pkg::DEPTH_W-1:0];
                    psu_pkg::REG_INVERT:    cur_invert    = cfg_wdata[0];
                    psu_pkg::REG_SIGNED:    cur_signed    = cfg_wdata[0];
                    psu_pkg::REG_ROW_WIDTH: cur_row_width = cfg_wdata[psu_pkg::ROW_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                busy = 1'b1;
                rec = offered_bytes.pop_front();
                unpack_byte(data_byte, n);
                // typed rows replace the prediction; state still advances
                if (rec.typed)
                    pending_samples.push_back('{rec.t_sample, rec.t_end, 1'b1});
                else
                    for (int j = 0; j < n; j++)
                        pending_samples.push_back(step_res[j]);
            end
            if (out_valid && !out_stall)
            begin
                busy = 1'b1;
                got = '{sample, row_end, byte_done};
                if (pending_samples.size() == 0)
                begin
                    note_mismatch("unexpected sample", '0, got);
                end
                else
                begin
                    want = pending_samples.pop_front();
                    if (got !== want)
                        note_mismatch("sample mismatch", want, got);
                end
            end
            quiet_cycles = busy ? 0 : quiet_cycles + 1;
        end
    end

    // Hang guard: too long with nothing accepted on any port.
    initial
    begin
        wait (rst_n === 1'b1);
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(negedge clk);
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Output side: per sample, stall for a random draw (none in eager
    // phases), or for a long stretch when the stimulus asks for one.
    // ------------------------------------------------------------------
    initial
    begin
        int hold;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req > 0)
            begin
                hold = hold_req;
                hold_req = 0;
            end
            else
            begin
                hold = rx_eager ? 0 : $urandom_range(0, 9);
            end
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // Offers one byte after an optional idle gap and returns at the falling edge
    // after it is taken. valid stays high across back-to-back bytes.
    task automatic send_byte(input logic [7:0] b, input logic typed,
                             input logic [psu_pkg::SAMPLE_W-1:0] t_sample,
                             input logic t_end, input int gap);
        begin
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            offered_bytes.push_back('{typed, t_sample, t_end});
            in_valid  <= 1'b1;
            data_byte <= b;
            do
                @(posedge clk);
            while (in_stall);
            @(negedge clk);
        end
    endtask

    // Stops sending, waits for every expected sample, then lets a byte
    // that produced nothing finish before the config may change.
    task automatic settle();
        begin
            in_valid <= 1'b0;
            while (pending_samples.size() != 0)
                @(negedge clk);
            repeat (SETTLE_CYCLES) @(negedge clk);
        end
    endtask

    // Writes all four registers back to back; write enable stays high.
    task automatic program_regs(input logic [psu_pkg::CFG_DATA_W-1:0] depth_w,
                                input logic [psu_pkg::CFG_DATA_W-1:0] inv_w,
                                input logic [psu_pkg::CFG_DATA_W-1:0] sgn_w,
                                input logic [psu_pkg::CFG_DATA_W-1:0] width_w);
        begin
            cfg_write_en <= 1'b1;
            cfg_index    <= psu_pkg::REG_BIT_DEPTH;
            cfg_wdata    <= depth_w;
            @(negedge clk);
            cfg_index    <= psu_pkg::REG_INVERT;
            cfg_wdata    <= inv_w;
            @(negedge clk);
            cfg_index    <= psu_pkg::REG_SIGNED;
            cfg_wdata    <= sgn_w;
            @(negedge clk);
            cfg_index    <= psu_pkg::REG_ROW_WIDTH;
            cfg_wdata    <= width_w;
            @(negedge clk);
            cfg_write_en <= 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus: directed table first, then random phases, each with its
    // own register settings. Held bits and the row count carry across
    // phases, so depth changes with bits pending come up naturally.
    // ------------------------------------------------------------------
    initial
    begin
        dir_row_t                    r;
        logic [psu_pkg::DEPTH_W-1:0] depth;
        logic                        inv;
        logic                        sgn;
        logic [psu_pkg::ROW_W-1:0]   width;
        logic [7:0]                  b;
        bit                          tx_eager;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        data_byte    = '0;
        cfg_write_en = 1'b0;
        cfg_index    = psu_pkg::REG_BIT_DEPTH;
        cfg_wdata    = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part; a run of write rows shares one settle
        for (int i = 0; i < N_DIR; i++)
        begin
            r = dir_rows[i];
            if (r.kind == ROW_WRITE)
            begin
                if (i == 0 || dir_rows[i-1].kind != ROW_WRITE)
                    settle();
                cfg_write_en <= 1'b1;
                cfg_index    <= r.idx;
                cfg_wdata    <= r.value;
                @(negedge clk);
                if (i == N_DIR - 1 || dir_rows[i+1].kind != ROW_WRITE)
                    cfg_write_en <= 1'b0;
            end
            else
            begin
                send_byte(r.value[7:0], r.typed, r.t_sample, r.t_end,
                          $urandom_range(0, 9));
            end
        end

        // random part
        for (int p = 0; p < N_PHASES; p++)
        begin
            inv = 1'($urandom_range(0, 1));
            sgn = 1'($urandom_range(0, 1));
            case (p)
                0:
                begin
                    depth = 5'd1;
                    width = 16'hFFFF;
                end
                1:
                begin
                    depth = 5'd16;
                    width = 16'd1;
                end
                2:
                begin
                    // long receiver hold-off: the block fills and stalls
                    depth = 5'd4;
                    sgn   = 1'b1;
                    width = 16'd200;
                end
                3:
                begin
                    depth = psu_pkg::DEPTH_W'($urandom_range(1, 16));
                    width = 16'd0;
                end
                default:
                begin
                    if ($urandom_range(0, 2) == 0)
                    begin
                        sgn = 1'b1;
                        case ($urandom_range(0, 2))
                            0:       depth = 5'd4;
                            1:       depth = 5'd10;
                            default: depth = 5'd12;
                        endcase
                    end
                    else
                    begin
                        depth = psu_pkg::DEPTH_W'($urandom_range(0, 31));
                    end
                    if ($urandom_range(0, 4) == 0)
                        width = psu_pkg::ROW_W'($urandom_range(0, 65535));
                    else
                        width = psu_pkg::ROW_W'($urandom_range(1, 24));
                end
            endcase

            settle();
            // junk in the unused upper data bits must be ignored
            program_regs({11'($urandom_range(0, 2047)), depth},
                         {15'($urandom_range(0, 32767)), inv},
                         {15'($urandom_range(0, 32767)), sgn},
                         width);

            tx_eager = ($urandom_range(0, 3) == 0);
            rx_eager = ($urandom_range(0, 3) == 0);
            if (p == 2)
            begin
                rx_eager = 1'b0;
                hold_req = LONG_HOLD;
            end

            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                // once, the sender waits for every sample mid-phase
                if (p == 4 && k == ITEMS_PER_PHASE / 2)
                    settle();
                b = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 9) == 0)
                    b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                send_byte(b, 1'b0, '0, 1'b0,
                          (tx_eager || p == 2) ? 0 : $urandom_range(0, 9));
            end
        end

        // drain, then give stray samples a chance to show up
        in_valid <= 1'b0;
        rx_eager = 1'b0;
        while (pending_samples.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (pending_samples.size() != 0)
            $display("%0d expected samples never arrived", pending_samples.size());

        if (mismatches == 0 && pending_samples.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
